// ===== hdl/lrcm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the lagged rolling correlation mean block.
package lrcm_pkg;

	// Delay line and sample geometry.
	localparam int MAX_WINDOW = 256;
	localparam int LINE_AW    = $clog2(MAX_WINDOW);
	localparam int SAMPLE_W   = 16;
	localparam int CFG_W      = 9;
	localparam int CNT_W      = 20;

	// Stream payload widths.
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 1;
	localparam int CFG_IDX_W  = 1;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 1'b1;

	// Register reset values.
	localparam logic [CFG_W-1:0] WINDOW_LEN_RST  = 9'd20;
	localparam logic [CFG_W-1:0] MIN_SAMPLES_RST = 9'd10;

	// Shared multiplier and wide datapath geometry.
	localparam int MUL_A_W = 49;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int WIDE_W  = 96;
	localparam int QUO_W   = 33;
	localparam int STEP_W  = 6;

	// Iteration counts of the divider and the square root unit.
	localparam logic [STEP_W-1:0] DIV_STEPS_CORR = 6'd33;
	localparam logic [STEP_W-1:0] DIV_STEPS_MEAN = 6'd17;
	localparam logic [STEP_W-1:0] SQRT_STEPS     = 6'd17;

	// One stored pair of the delay line.
	typedef struct packed {
		logic                       ok;
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
	} pair_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_GATE,
		ST_VAR,
		ST_CHECK,
		ST_ABS,
		ST_PROD,
		ST_PWAIT,
		ST_DIV_INIT,
		ST_DIV,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_ADD,
		ST_FINISH,
		ST_EMIT
	} state_t;

	// Operations of the shared multiplier, in issue order.
	typedef enum logic [3:0] {
		OP_RM_XX,
		OP_RM_YY,
		OP_RM_XY,
		OP_ADD_XX,
		OP_ADD_YY,
		OP_ADD_XY,
		OP_N_SXX,
		OP_SX_SX,
		OP_N_SYY,
		OP_SY_SY,
		OP_N_SXY,
		OP_SX_SY,
		OP_D_LO,
		OP_D_HI,
		OP_C_LO,
		OP_C_HI
	} mul_op_t;

endpackage

// ===== hdl/lagged_rolling_correlation_mean_top.sv =====
`timescale 1ns / 1ps
// Lagged rolling correlation mean: sequencer with a shared multiplier, divider and root unit.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: feature, return; s_tuser: presence; s_tlast
// m_       out  m_tvalid/m_tready  m_tdata: ic_value, windows_used; m_tuser: ic_valid
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// The first item of a series only latches its feature; a later item updates the window
// sums, and when it closes a window that is evaluated and shows nonzero spread it forms
// the spread products on one shared 49x25 multiplier and runs 33 divider steps and 17
// root steps. An item marked last adds the mean division, skipped when no window was
// counted. Reset clears all control state; the delay line needs no clearing.
// While a result waits on m_tready the block keeps taking items; it stalls only when a
// second result is ready before the first has been taken.
module lagged_rolling_correlation_mean_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lrcm_pkg::IN_DATA_W-1:0]    s_tdata,   // feature_sample[15:0], return_sample[31:16]
	input  logic [lrcm_pkg::IN_USER_W-1:0]    s_tuser,   // feature_present[0], return_present[1]
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lrcm_pkg::OUT_DATA_W-1:0]   m_tdata,   // ic_value[15:0], windows_used[35:16], zero
	output logic [lrcm_pkg::OUT_USER_W-1:0]   m_tuser,   // ic_valid[0]
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lrcm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lrcm_pkg::CFG_W-1:0]        cfg_data
);
	import lrcm_pkg::*;

	// Sequencer and configuration.
	state_t                  state_q, state_d;
	logic [CFG_W-1:0]        window_len_q, min_samples_q;
	logic [CFG_W-1:0]        w_eff;

	// Series state.
	logic signed [SAMPLE_W-1:0] held_x_q;
	logic                    held_p_q;
	logic [CFG_W-1:0]        line_fill_q;
	logic [LINE_AW-1:0]      line_pos_q;
	logic [LINE_AW-1:0]      pos_eff;
	logic [CFG_W-1:0]        present_q;
	logic signed [24:0]      sx_q, sy_q;
	logic signed [40:0]      sxy_q;
	logic [39:0]             sxx_q, syy_q;
	logic [CNT_W-1:0]        steps_q;
	logic signed [36:0]      corr_q;
	logic [CNT_W-1:0]        wins_q;

	// Latched request.
	logic signed [SAMPLE_W-1:0] in_x_q, in_y_q;
	logic                    in_xp_q, in_yp_q, in_last_q;

	// Delay line.
	pair_t                   line_mem [MAX_WINDOW];
	pair_t                   rd_q;
	pair_t                   wr_pair;
	logic                    full_q, eval_q;

	// Shared multiplier.
	mul_op_t                 op_q, op_s1;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_s1;
	logic                    pvalid_s1;

	// Window spreads and products.
	logic [47:0]             vx_q, vy_q, cov_abs_q;
	logic signed [48:0]      cov_q;
	logic                    cov_neg_q;
	logic [WIDE_W-1:0]       d_q, c2_q;

	// Shared divider and square root unit.
	logic [WIDE_W-1:0]       rem_q, den_q;
	logic [QUO_W-1:0]        nsh_q, quo_q;
	logic [STEP_W-1:0]       step_q;
	logic                    mean_mode_q;
	logic [QUO_W-1:0]        sop_q, one_q;
	logic [QUO_W:0]          res_q;

	// Output register.
	logic                    out_valid_q, icv_q;
	logic [15:0]             ic_q;
	logic [CNT_W-1:0]        wused_q;

	// Control strobes.
	logic                    item_acc, cfg_acc, upd_first, mul_issue, emit_go;
	logic                    rm_en, add_en, eval_ok;

	// Combinational helpers.
	logic signed [16:0]      dx, dy;
	logic [CFG_W-1:0]        fill_new;
	logic [CFG_W-1:0]        pos_inc;
	logic [97:0]             trial;
	logic [QUO_W:0]          cand;
	logic [17:0]             rs1;
	logic signed [36:0]      m_signed;
	logic [36:0]             mean_mag;
	logic [38:0]             mean_num;
	logic [16:0]             q17;
	logic [15:0]             ic_d;

	// Effective window length and write position.
	always_comb begin
		if (window_len_q == '0) begin
			w_eff = 9'd1;
		end else if (window_len_q > CFG_W'(MAX_WINDOW)) begin
			w_eff = CFG_W'(MAX_WINDOW);
		end else begin
			w_eff = window_len_q;
		end
		pos_eff = ({1'b0, line_pos_q} >= w_eff) ? '0 : line_pos_q;
		pos_inc = {1'b0, line_pos_q} + 9'd1;
		fill_new = (line_fill_q < w_eff) ? line_fill_q + 9'd1 : line_fill_q;
	end

	// Pair removal and insertion flags, and the linear sum deltas.
	always_comb begin
		rm_en   = full_q && rd_q.ok;
		add_en  = held_p_q && in_yp_q;
		dx      = (add_en ? 17'(held_x_q) : 17'sd0) - (rm_en ? 17'(rd_q.x) : 17'sd0);
		dy      = (add_en ? 17'(in_y_q) : 17'sd0) - (rm_en ? 17'(rd_q.y) : 17'sd0);
		wr_pair = '{ok: add_en, x: held_x_q, y: in_y_q};
		eval_ok = eval_q && (wins_q != '1) && (present_q != '0) && !(present_q < min_samples_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					state_d = (steps_q == '0) ? ST_FINISH : ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (op_q == OP_ADD_XY) begin
					state_d = ST_GATE;
				end
			end
			ST_GATE: begin
				state_d = eval_ok ? ST_VAR : ST_FINISH;
			end
			ST_VAR: begin
				if (op_q == OP_SX_SY) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = (vx_q == '0 || vy_q == '0) ? ST_FINISH : ST_ABS;
			end
			ST_ABS: begin
				state_d = ST_PROD;
			end
			ST_PROD: begin
				if (op_q == OP_C_HI) begin
					state_d = ST_PWAIT;
				end
			end
			ST_PWAIT: begin
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == 6'd1) begin
					state_d = mean_mode_q ? ST_EMIT : ST_SQRT_INIT;
				end
			end
			ST_SQRT_INIT: begin
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (step_q == 6'd1) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!in_last_q) begin
					state_d = ST_IDLE;
				end else if (wins_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_DIV_INIT;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshakes and strobes.
	always_comb begin
		s_tready  = 1'b0;
		cfg_ready = 1'b0;
		upd_first = 1'b0;
		mul_issue = 1'b0;
		emit_go   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				s_tready  = !cfg_valid;
			end
			ST_UPDATE: begin
				upd_first = (op_q == OP_RM_XX);
				mul_issue = (op_q <= OP_RM_XY) ? rm_en : add_en;
			end
			ST_VAR, ST_PROD: begin
				mul_issue = 1'b1;
			end
			ST_EMIT: begin
				emit_go = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
		item_acc = s_tvalid && s_tready;
		cfg_acc  = cfg_valid && cfg_ready;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (op_q)
			OP_RM_XX:  begin mul_a = MUL_A_W'(rd_q.x);   mul_b = MUL_B_W'(rd_q.x); end
			OP_RM_YY:  begin mul_a = MUL_A_W'(rd_q.y);   mul_b = MUL_B_W'(rd_q.y); end
			OP_RM_XY:  begin mul_a = MUL_A_W'(rd_q.x);   mul_b = MUL_B_W'(rd_q.y); end
			OP_ADD_XX: begin mul_a = MUL_A_W'(held_x_q); mul_b = MUL_B_W'(held_x_q); end
			OP_ADD_YY: begin mul_a = MUL_A_W'(in_y_q);   mul_b = MUL_B_W'(in_y_q); end
			OP_ADD_XY: begin mul_a = MUL_A_W'(held_x_q); mul_b = MUL_B_W'(in_y_q); end
			OP_N_SXX:  begin
				mul_a = $signed({9'd0, sxx_q});
				mul_b = $signed({16'd0, present_q});
			end
			OP_SX_SX:  begin mul_a = MUL_A_W'(sx_q); mul_b = sx_q; end
			OP_N_SYY:  begin
				mul_a = $signed({9'd0, syy_q});
				mul_b = $signed({16'd0, present_q});
			end
			OP_SY_SY:  begin mul_a = MUL_A_W'(sy_q); mul_b = sy_q; end
			OP_N_SXY:  begin
				mul_a = MUL_A_W'(sxy_q);
				mul_b = $signed({16'd0, present_q});
			end
			OP_SX_SY:  begin mul_a = MUL_A_W'(sx_q); mul_b = sy_q; end
			OP_D_LO:   begin
				mul_a = $signed({1'b0, vx_q});
				mul_b = $signed({1'b0, vy_q[23:0]});
			end
			OP_D_HI:   begin
				mul_a = $signed({1'b0, vx_q});
				mul_b = $signed({1'b0, vy_q[47:24]});
			end
			OP_C_LO:   begin
				mul_a = $signed({1'b0, cov_abs_q});
				mul_b = $signed({1'b0, cov_abs_q[23:0]});
			end
			OP_C_HI:   begin
				mul_a = $signed({1'b0, cov_abs_q});
				mul_b = $signed({1'b0, cov_abs_q[47:24]});
			end
			default:   begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Divider step, root step, window correlation and mean helpers.
	always_comb begin
		trial    = {1'b0, rem_q, nsh_q[QUO_W-1]} - {2'b0, den_q};
		cand     = res_q + {1'b0, one_q};
		rs1      = {1'b0, res_q[16:0]} + 18'd1;
		m_signed = cov_neg_q ? -$signed({20'd0, rs1[17:1]}) : $signed({20'd0, rs1[17:1]});
		mean_mag = corr_q[36] ? 37'(-corr_q) : 37'(corr_q);
		mean_num = {1'b0, mean_mag, 1'b0} + {19'd0, wins_q};
		q17      = quo_q[16:0];
		if (wins_q == '0) begin
			ic_d = '0;
		end else if (!corr_q[36]) begin
			ic_d = (q17 > 17'd32767) ? 16'h7FFF : q17[15:0];
		end else begin
			ic_d = (q17 > 17'd32768) ? 16'h8000 : 16'(~q17 + 17'd1);
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Delay line memory: one read when a request is taken, one write in the update.
	always_ff @(posedge clk) begin
		if (upd_first) begin
			line_mem[line_pos_q] <= wr_pair;
		end
		if (item_acc) begin
			rd_q <= line_mem[pos_eff];
		end
	end

	// Shared multiplier with its result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_s1 <= 1'b0;
			op_s1     <= OP_RM_XX;
		end else begin
			pvalid_s1 <= mul_issue;
			op_s1     <= op_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// Multiplier operation counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_RM_XX;
		end else if (item_acc) begin
			op_q <= OP_RM_XX;
		end else if (state_q == ST_UPDATE || state_q == ST_VAR || state_q == ST_PROD) begin
			op_q <= mul_op_t'(op_q + 4'd1);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q  <= WINDOW_LEN_RST;
			min_samples_q <= MIN_SAMPLES_RST;
		end else if (cfg_acc) begin
			if (cfg_index == CFG_WINDOW_LEN) begin
				window_len_q <= cfg_data;
			end else begin
				min_samples_q <= cfg_data;
			end
		end
	end

	// Latched request fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_xp_q     <= 1'b0;
			in_yp_q     <= 1'b0;
			in_last_q   <= 1'b0;
			full_q      <= 1'b0;
			eval_q      <= 1'b0;
			mean_mode_q <= 1'b0;
		end else begin
			if (item_acc) begin
				in_xp_q     <= s_tuser[0];
				in_yp_q     <= s_tuser[1];
				in_last_q   <= s_tlast;
				full_q      <= (line_fill_q >= w_eff);
				mean_mode_q <= 1'b0;
			end
			if (upd_first) begin
				eval_q <= (fill_new >= w_eff);
			end
			if (state_q == ST_FINISH) begin
				mean_mode_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			in_x_q <= $signed(s_tdata[15:0]);
			in_y_q <= $signed(s_tdata[31:16]);
		end
	end

	// Series state: running sums, line position, counts and the correlation total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= '0;
			held_p_q    <= 1'b0;
			line_fill_q <= '0;
			line_pos_q  <= '0;
			present_q   <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			sxy_q       <= '0;
			sxx_q       <= '0;
			syy_q       <= '0;
			steps_q     <= '0;
			corr_q      <= '0;
			wins_q      <= '0;
		end else if ((cfg_acc && cfg_index == CFG_WINDOW_LEN) || (emit_go)) begin
			held_x_q    <= '0;
			held_p_q    <= 1'b0;
			line_fill_q <= '0;
			line_pos_q  <= '0;
			present_q   <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			sxy_q       <= '0;
			sxx_q       <= '0;
			syy_q       <= '0;
			steps_q     <= '0;
			corr_q      <= '0;
			wins_q      <= '0;
		end else begin
			if (item_acc) begin
				line_pos_q <= pos_eff;
			end
			// Linear sums, pair count and line pointers move once per pair.
			if (upd_first) begin
				sx_q        <= sx_q + 25'(dx);
				sy_q        <= sy_q + 25'(dy);
				present_q   <= present_q + {8'd0, add_en} - {8'd0, rm_en};
				line_pos_q  <= (pos_inc >= w_eff) ? '0 : pos_inc[LINE_AW-1:0];
				line_fill_q <= fill_new;
			end
			// Product sums are updated from the registered multiplier result in the cycle after issue.
			if (pvalid_s1) begin
				case (op_s1)
					OP_RM_XX:  sxx_q <= sxx_q - prod_s1[39:0];
					OP_RM_YY:  syy_q <= syy_q - prod_s1[39:0];
					OP_RM_XY:  sxy_q <= sxy_q - prod_s1[40:0];
					OP_ADD_XX: sxx_q <= sxx_q + prod_s1[39:0];
					OP_ADD_YY: syy_q <= syy_q + prod_s1[39:0];
					OP_ADD_XY: sxy_q <= sxy_q + prod_s1[40:0];
					default:   sxx_q <= sxx_q;
				endcase
			end
			if (state_q == ST_ADD) begin
				corr_q <= corr_q + m_signed;
				wins_q <= wins_q + 20'd1;
			end
			if (state_q == ST_FINISH) begin
				held_x_q <= in_xp_q ? in_x_q : '0;
				held_p_q <= in_xp_q;
				if (steps_q != '1) begin
					steps_q <= steps_q + 20'd1;
				end
			end
		end
	end

	// Window spreads and wide products.
	always_ff @(posedge clk) begin
		if (pvalid_s1) begin
			case (op_s1)
				OP_N_SXX: vx_q  <= prod_s1[47:0];
				OP_SX_SX: vx_q  <= vx_q - prod_s1[47:0];
				OP_N_SYY: vy_q  <= prod_s1[47:0];
				OP_SY_SY: vy_q  <= vy_q - prod_s1[47:0];
				OP_N_SXY: cov_q <= prod_s1[48:0];
				OP_SX_SY: cov_q <= cov_q - prod_s1[48:0];
				OP_D_LO:  d_q   <= {24'd0, prod_s1[71:0]};
				OP_D_HI:  d_q   <= d_q + {prod_s1[71:0], 24'd0};
				OP_C_LO:  c2_q  <= {24'd0, prod_s1[71:0]};
				OP_C_HI:  c2_q  <= c2_q + {prod_s1[71:0], 24'd0};
				default:  d_q   <= d_q;
			endcase
		end
		if (state_q == ST_ABS) begin
			cov_neg_q <= cov_q[48];
			cov_abs_q <= cov_q[48] ? 48'(-cov_q) : cov_q[47:0];
		end
	end

	// Shared restoring divider and digit-by-digit square root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_DIV_INIT) begin
			step_q <= mean_mode_q ? DIV_STEPS_MEAN : DIV_STEPS_CORR;
		end else if (state_q == ST_SQRT_INIT) begin
			step_q <= SQRT_STEPS;
		end else if (state_q == ST_DIV || state_q == ST_SQRT) begin
			step_q <= step_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DIV_INIT: begin
				quo_q <= '0;
				if (mean_mode_q) begin
					rem_q <= {74'd0, mean_num[38:17]};
					nsh_q <= {mean_num[16:0], 16'd0};
					den_q <= {75'd0, wins_q, 1'b0};
				end else begin
					rem_q <= {1'b0, c2_q[WIDE_W-1:1]};
					nsh_q <= {c2_q[0], 32'd0};
					den_q <= d_q;
				end
			end
			ST_DIV: begin
				nsh_q <= {nsh_q[QUO_W-2:0], 1'b0};
				if (!trial[97]) begin
					rem_q <= trial[WIDE_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[WIDE_W-2:0], nsh_q[QUO_W-1]};
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			ST_SQRT_INIT: begin
				sop_q <= quo_q;
				res_q <= '0;
				one_q <= {1'b1, 32'd0};
			end
			ST_SQRT: begin
				one_q <= {2'b00, one_q[QUO_W-1:2]};
				if ({1'b0, sop_q} >= cand) begin
					sop_q <= sop_q - cand[QUO_W-1:0];
					res_q <= {1'b0, res_q[QUO_W:1]} + {1'b0, one_q};
				end else begin
					res_q <= {1'b0, res_q[QUO_W:1]};
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			icv_q       <= 1'b0;
			ic_q        <= '0;
			wused_q     <= '0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
			icv_q       <= (wins_q != '0);
			ic_q        <= ic_d;
			wused_q     <= wins_q;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, wused_q, ic_q};
	assign m_tuser  = icv_q;

endmodule

// ===== hdl/lrcm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the lagged rolling correlation mean block, with its bind.
module lrcm_port_checks (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lrcm_pkg::OUT_DATA_W-1:0]   m_tdata,
	input logic [lrcm_pkg::OUT_USER_W-1:0]   m_tuser,
	input logic                              cfg_ready
);
	import lrcm_pkg::*;

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A result without counted windows carries zeros.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("invalid result carries nonzero payload");

	// A valid mean always reports at least one window.
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[OUT_DATA_W-5:16] != '0)
		else $error("valid mean with zero window count");

	// Once a request is taken the block is busy for the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !cfg_ready)
		else $error("request taken while still working");

	// Requests are only taken when configuration could be taken too.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> cfg_ready)
		else $error("input ready outside idle");

endmodule

bind lagged_rolling_correlation_mean_top lrcm_port_checks u_lrcm_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.cfg_ready (cfg_ready)
);
